/* sv/tracker_row_sequencer_defines.svh */
// Assertion macros for the row sequencer
`ifndef TRACKER_ROW_SEQUENCER_DEFINES_SVH
`define TRACKER_ROW_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TRS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/trs_pkg.sv */
package trs_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_START      = 3'd1,
        OP_STOP       = 3'd2,
        OP_REPLAY     = 3'd3,
        OP_JAM        = 3'd4,
        OP_WRITE_CELL = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_PLAY  = 3'd4,
        CMD_JAM   = 3'd5,
        CMD_WRITE = 3'd6
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] param;
        logic [3:0] effect;
        logic [7:0] patch;
        logic [7:0] note;
    } cell_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [5:0] row;
        logic [2:0] channel;
        logic       sounding;
        cell_t      entry;
    } cmd_t;

    typedef struct packed {
        logic        is_playing;
        logic [5:0]  cur_row;
        logic        key_on;
        logic [10:0] freq_number;
        logic [2:0]  octave_block;
        logic        set_note;
        logic [7:0]  load_patch;
        logic        key_off;
        logic        full_release;
        logic [2:0]  out_channel;
    } out_t;

    localparam logic [7:0] NOTE_EMPTY  = 8'h00;
    localparam logic [7:0] NOTE_OFF    = 8'hff;
    localparam logic [3:0] EFF_TEMPO   = 4'hf;
    localparam logic [7:0] PARAM_HALT  = 8'h00;
    localparam logic [7:0] SPEED_RESET = 8'd6;
    localparam int         SEMITONES   = 12;
    localparam int         RECIP_12    = 171;

    function automatic logic [10:0] fnum_lookup(input logic [3:0] semi);
        logic [10:0] f;
        case (semi)
            4'd0:    f = 11'd617;
            4'd1:    f = 11'd653;
            4'd2:    f = 11'd692;
            4'd3:    f = 11'd733;
            4'd4:    f = 11'd777;
            4'd5:    f = 11'd823;
            4'd6:    f = 11'd872;
            4'd7:    f = 11'd924;
            4'd8:    f = 11'd979;
            4'd9:    f = 11'd1037;
            4'd10:   f = 11'd1099;
            4'd11:   f = 11'd1164;
            default: f = 11'd0;
        endcase
        return f;
    endfunction

    function automatic logic sounding_note(input logic [7:0] note);
        return (note != NOTE_EMPTY) && (note != NOTE_OFF);
    endfunction

    function automatic out_t make_out(
        input logic [2:0] ch,
        input logic       hr,
        input logic       ko,
        input logic [7:0] patch,
        input logic       sn,
        input logic [7:0] note,
        input logic       kon,
        input logic [5:0] row,
        input logic       play
    );
        out_t        o;
        logic [7:0]  m;
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  semi;
        m    = note - 8'd1;
        prod = 16'(m) * 16'(RECIP_12);
        q    = prod[15:11];
        semi = m - 8'(8'(q) * 8'(SEMITONES));
        o.out_channel  = ch;
        o.full_release = hr;
        o.key_off      = ko;
        o.load_patch   = patch;
        o.set_note     = sn;
        o.octave_block = sn ? q[2:0] : 3'd0;
        o.freq_number  = sn ? fnum_lookup(semi[3:0]) : 11'd0;
        o.key_on       = kon;
        o.cur_row      = row;
        o.is_playing   = play;
        return o;
    endfunction

endpackage

/* sv/trs_front.sv */
module trs_front
    import trs_pkg::*;
#(
    parameter int ROWS     = 64,
    parameter int CHANNELS = 6
)
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index, channel, note_code, patch_number, effect_code, effect_param
    input  logic [2:0]  s_tuser,   // op
    input  logic        accept_en,
    input  logic        q_ready,
    output logic        q_push,
    output cmd_t        q_data
);

    function automatic logic [5:0] row_wrap(input logic [5:0] r);
        logic [8:0] v;
        v = 9'(r);
        for (int k = 5; k >= 0; k--)
        begin
            if (int'(v) >= (ROWS << k))
            begin
                v = 9'(int'(v) - (ROWS << k));
            end
        end
        return v[5:0];
    endfunction

    logic [2:0] ch;
    logic       ch_ok;
    op_t        op;

    assign op       = op_t'(s_tuser);
    assign ch       = s_tdata[8:6];
    assign ch_ok    = 32'(ch) < CHANNELS;
    assign s_tready = q_ready && accept_en;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        q_data.row          = row_wrap(s_tdata[5:0]);
        q_data.channel      = ch;
        q_data.entry.note   = s_tdata[16:9];
        q_data.entry.patch  = s_tdata[24:17];
        q_data.entry.effect = s_tdata[28:25];
        q_data.entry.param  = s_tdata[36:29];
        q_data.sounding     = sounding_note(s_tdata[16:9]);
        unique case (op)
            OP_TICK:       q_data.kind = CMD_TICK;
            OP_START:      q_data.kind = CMD_START;
            OP_STOP:       q_data.kind = CMD_STOP;
            OP_REPLAY:     q_data.kind = CMD_PLAY;
            OP_JAM:        q_data.kind = ch_ok ? CMD_JAM : CMD_NONE;
            OP_WRITE_CELL: q_data.kind = ch_ok ? CMD_WRITE : CMD_NONE;
            default:       q_data.kind = CMD_NONE;
        endcase
    end

endmodule

/* sv/trs_cmd_queue.sv */
module trs_cmd_queue
    import trs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic ready,
    input  logic pop,
    output logic valid,
    output cmd_t pop_data
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign ready    = count_reg != 2'd2;
    assign valid    = count_reg != 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* sv/trs_back.sv */
`include "tracker_row_sequencer_defines.svh"

module trs_back
    import trs_pkg::*;
#(
    parameter int ROWS     = 64,
    parameter int CHANNELS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        accept_en,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_channel, full_release, key_off, load_patch, set_note,
                                   // octave_block, freq_number, key_on, cur_row, is_playing
    output logic        m_tlast
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [2:0]    CH_LAST  = 3'(CHANNELS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADR_LAST = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_STOP,
        ST_FIRE,
        ST_EMIT1
    } state_t;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] fire_addr_reg;
    logic [AW-1:0] fire_addr_next;
    logic [2:0]    ch_reg;
    logic [RW-1:0] playhead_reg;
    logic [7:0]    tick_reg;
    logic [7:0]    speed_reg;
    logic          playing_reg;
    logic [8:0]    tick_n_reg;
    logic [7:0]    shift_reg;
    logic [7:0]    rem_reg;
    logic [2:0]    div_cnt_reg;
    logic          m_tvalid_reg;
    logic          m_tlast_reg;
    out_t          m_out_reg;
    cell_t         mem [DEPTH];
    cell_t         rd_data_reg;

    logic          out_free;
    logic          out_emit;
    logic [7:0]    sp;
    logic [8:0]    rem_shift;
    logic [7:0]    rem_step;
    logic          div_last;
    logic          tick_fire;
    logic [RW-1:0] ph_inc;
    logic          fire_go;
    logic [RW-1:0] go_row;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic [5:0]    row6;
    logic          ch_last;
    logic          fire_play;
    logic [7:0]    tick_inc;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_emit  = out_free && (state_reg == ST_STOP || state_reg == ST_FIRE
                                    || state_reg == ST_EMIT1);
    assign accept_en = state_reg != ST_CLEAR;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tdata   = 40'(m_out_reg);
    assign sp        = (speed_reg == 8'd0) ? 8'd1 : speed_reg;
    assign rem_shift = {rem_reg, shift_reg[7]};
    assign rem_step  = (rem_shift >= 9'(sp)) ? 8'(rem_shift - 9'(sp)) : rem_shift[7:0];
    assign div_last  = div_cnt_reg == 3'd0;
    assign tick_fire = rem_step == 8'd0;
    assign ph_inc    = (playhead_reg == ROW_LAST) ? '0 : playhead_reg + RW'(1);
    assign row6      = 6'(playhead_reg);
    assign ch_last   = ch_reg == CH_LAST;
    assign tick_inc  = tick_reg + 8'd1;
    assign fire_play = (rd_data_reg.effect == EFF_TEMPO && rd_data_reg.param == PARAM_HALT)
                       ? 1'b0 : playing_reg;

    always_comb
    begin
        fire_go = 1'b0;
        go_row  = RW'(cmd_reg.row);
        unique case (state_reg)
            ST_IDLE:
            begin
                go_row = RW'(q_data.row);
                if (q_valid && !playing_reg
                    && (q_data.kind == CMD_START || q_data.kind == CMD_PLAY))
                begin
                    fire_go = 1'b1;
                end
            end
            ST_DIV:
            begin
                go_row = ph_inc;
                fire_go = div_last && tick_fire;
            end
            ST_STOP:
            begin
                fire_go = out_free && ch_last
                          && (cmd_reg.kind == CMD_START || cmd_reg.kind == CMD_PLAY);
            end
            default:
            begin
                fire_go = 1'b0;
            end
        endcase
        if (fire_go)
        begin
            fire_addr_next = AW'(AW'(go_row) * AW'(CHANNELS));
        end
        else if (state_reg == ST_FIRE && out_free && !ch_last)
        begin
            fire_addr_next = fire_addr_reg + AW'(1);
        end
        else
        begin
            fire_addr_next = fire_addr_reg;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = q_pop && (q_data.kind == CMD_WRITE);
            mem_waddr = AW'(AW'(q_data.row) * AW'(CHANNELS) + AW'(q_data.channel));
            mem_wdata = q_data.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[fire_addr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= '0;
            clr_addr_reg  <= '0;
            fire_addr_reg <= '0;
            ch_reg        <= 3'd0;
            playhead_reg  <= '0;
            tick_reg      <= 8'd0;
            speed_reg     <= SPEED_RESET;
            playing_reg   <= 1'b0;
            tick_n_reg    <= 9'd0;
            shift_reg     <= 8'd0;
            rem_reg       <= 8'd0;
            div_cnt_reg   <= 3'd0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
            m_out_reg     <= '0;
        end
        else
        begin
            fire_addr_reg <= fire_addr_next;
            if (out_free)
            begin
                m_tvalid_reg <= out_emit;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == ADR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_data;
                        ch_reg  <= 3'd0;
                        unique case (q_data.kind)
                            CMD_TICK:
                            begin
                                if (playing_reg)
                                begin
                                    tick_n_reg  <= 9'(tick_reg) + 9'd1;
                                    shift_reg   <= tick_inc;
                                    rem_reg     <= 8'd0;
                                    div_cnt_reg <= 3'd7;
                                    state_reg   <= ST_DIV;
                                end
                                else
                                begin
                                    state_reg <= ST_EMIT1;
                                end
                            end
                            CMD_START, CMD_PLAY:
                            begin
                                if (playing_reg)
                                begin
                                    playing_reg <= 1'b0;
                                    state_reg   <= ST_STOP;
                                end
                                else
                                begin
                                    if (q_data.kind == CMD_START)
                                    begin
                                        playing_reg  <= 1'b1;
                                        playhead_reg <= RW'(q_data.row);
                                        tick_reg     <= 8'd0;
                                    end
                                    state_reg <= ST_FIRE;
                                end
                            end
                            CMD_STOP:
                            begin
                                playing_reg <= 1'b0;
                                state_reg   <= ST_STOP;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT1;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_step;
                    shift_reg   <= {shift_reg[6:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 3'd1;
                    if (div_last)
                    begin
                        if (tick_fire)
                        begin
                            tick_reg     <= 8'd0;
                            playhead_reg <= ph_inc;
                            state_reg    <= ST_FIRE;
                        end
                        else
                        begin
                            tick_reg  <= tick_n_reg[7:0];
                            state_reg <= ST_EMIT1;
                        end
                    end
                end
                ST_STOP:
                begin
                    if (out_free)
                    begin
                        m_tlast_reg  <= ch_last && (cmd_reg.kind == CMD_STOP);
                        m_out_reg    <= make_out(ch_reg, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0,
                                                 1'b0, row6, 1'b0);
                        ch_reg       <= ch_last ? 3'd0 : ch_reg + 3'd1;
                        if (ch_last)
                        begin
                            if (cmd_reg.kind == CMD_START)
                            begin
                                playing_reg  <= 1'b1;
                                playhead_reg <= RW'(cmd_reg.row);
                                tick_reg     <= 8'd0;
                                state_reg    <= ST_FIRE;
                            end
                            else if (cmd_reg.kind == CMD_PLAY)
                            begin
                                state_reg <= ST_FIRE;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_FIRE:
                begin
                    if (out_free)
                    begin
                        if (rd_data_reg.effect == EFF_TEMPO)
                        begin
                            if (rd_data_reg.param == PARAM_HALT)
                            begin
                                playing_reg <= 1'b0;
                            end
                            else
                            begin
                                speed_reg <= rd_data_reg.param;
                            end
                        end
                        m_tlast_reg  <= ch_last;
                        m_out_reg    <= make_out(ch_reg, 1'b0,
                                                 rd_data_reg.note != NOTE_EMPTY,
                                                 rd_data_reg.patch,
                                                 sounding_note(rd_data_reg.note),
                                                 rd_data_reg.note,
                                                 sounding_note(rd_data_reg.note),
                                                 row6, fire_play);
                        ch_reg       <= ch_last ? 3'd0 : ch_reg + 3'd1;
                        if (ch_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT1:
                begin
                    if (out_free)
                    begin
                        m_tlast_reg  <= 1'b1;
                        if (cmd_reg.kind == CMD_JAM)
                        begin
                            m_out_reg <= make_out(cmd_reg.channel, 1'b0, 1'b1,
                                                  cmd_reg.sounding ? cmd_reg.entry.patch : 8'd0,
                                                  cmd_reg.sounding, cmd_reg.entry.note,
                                                  cmd_reg.sounding, row6, playing_reg);
                        end
                        else
                        begin
                            m_out_reg <= make_out(3'd0, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0,
                                                  1'b0, row6, playing_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TRS_ASSERT_IMPL(a_clear_blocks_pop, state_reg == ST_CLEAR, !q_pop && !accept_en, "pop during clear pass")
    `TRS_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_reg != ST_IDLE, "command popped but back end stayed idle")
    `TRS_ASSERT_IMPL(a_fire_ch_range, state_reg == ST_FIRE, ch_reg <= CH_LAST, "fire channel out of range")
    `TRS_ASSERT_NEXT(a_stop_keeps_halted, state_reg == ST_STOP, !playing_reg || state_reg == ST_FIRE, "playing set during stop sequence")
    `TRS_ASSERT_IMPL(a_rem_below_speed, state_reg == ST_DIV, rem_reg < sp, "tick remainder not below speed")

endmodule

/* sv/tracker_row_sequencer.sv */
// Channel   Dir  Width  Contents
// s_axis    in   40+3   tdata: row_index, channel, note_code, patch_number, effect_code,
//                       effect_param; tuser: op
// m_axis    out  40+1   tdata: one channel command; tlast: last command of the input
//
// Each command is dispatched from the idle state, then streams one result per cycle while
// m_tready is high: a fired row yields CHANNELS results, a start or replay while playing
// 2*CHANNELS, a stop CHANNELS, a jam or status 1. A playing tick first runs the bit-serial
// tick/speed remainder and fires a row only on a zero remainder. After reset a clearing pass
// zeroes all ROWS*CHANNELS pattern memory entries; s_tready stays low meanwhile.
// A two-entry command queue decouples input from execution; m_tready low stalls only
// the back end until the queue fills.
module tracker_row_sequencer
    import trs_pkg::*;
#(
    parameter int ROWS     = 64,
    parameter int CHANNELS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index[5:0], channel[8:6], note_code[16:9],
                                   // patch_number[24:17], effect_code[28:25], effect_param[36:29]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_channel[2:0], full_release[3], key_off[4], load_patch[12:5],
                                   // set_note[13], octave_block[16:14], freq_number[27:17],
                                   // key_on[28], cur_row[34:29], is_playing[35]
    output logic        m_tlast
);

    logic push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    logic accept_en;
    cmd_t push_data;
    cmd_t pop_data;

    trs_front #(
        .ROWS     (ROWS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .accept_en (accept_en),
        .q_ready   (q_ready),
        .q_push    (push),
        .q_data    (push_data)
    );

    trs_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    trs_back #(
        .ROWS     (ROWS),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .accept_en (accept_en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* sim/tracker_row_sequencer_tb.sv */
module tracker_row_sequencer_tb;
    import trs_pkg::*;

    localparam int ROWS         = 64;
    localparam int CHANNELS     = 6;
    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 64;
    localparam int DIR_ITEMS    = 25;
    localparam int MAX_PRINTS   = 40;

    localparam logic [2:0] OP_RSVD6  = 3'd6;
    localparam logic [2:0] OP_RSVD7  = 3'd7;
    localparam logic [3:0] EFF_PLAIN = 4'he;
    localparam logic [3:0] EFF_NONE  = 4'h0;

    localparam logic [10:0] FNUM_TBL [12] = '{
        11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
        11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
    };

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] row;
        logic [2:0] ch;
        logic [7:0] note;
        logic [7:0] patch;
        logic [3:0] eff;
        logic [7:0] par;
        logic       typed;
    } stim_t;

    typedef struct packed {
        out_t cmd;
        logic last;
    } chan_cmd_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    chan_cmd_t   pending_cmds [$];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          quiet      = 1'b0;

    cell_t       song [ROWS*CHANNELS];
    logic [5:0]  head_row;
    logic [7:0]  tick_cnt;
    logic [7:0]  speed;
    logic        running;

    stim_t       dir_tbl [DIR_ITEMS];

    tracker_row_sequencer #(
        .ROWS     (ROWS),
        .CHANNELS (CHANNELS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void push_cmd(input logic [2:0] ch, input logic hr, input logic ko,
                                     input logic [7:0] patch, input logic sn,
                                     input logic [7:0] note, input logic kon);
        chan_cmd_t  e;
        logic [7:0] m;
        m = note - 8'd1;
        e.cmd.out_channel  = ch;
        e.cmd.full_release = hr;
        e.cmd.key_off      = ko;
        e.cmd.load_patch   = patch;
        e.cmd.set_note     = sn;
        e.cmd.octave_block = sn ? 3'((m / 8'd12) % 8'd8) : 3'd0;
        e.cmd.freq_number  = sn ? FNUM_TBL[m % 8'd12] : 11'd0;
        e.cmd.key_on       = kon;
        e.cmd.cur_row      = head_row;
        e.cmd.is_playing   = running;
        e.last             = 1'b0;
        pending_cmds.push_back(e);
    endfunction

    function automatic void halt_channels();
        running = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            push_cmd(3'(c), 1'b1, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
    endfunction

    function automatic void fire_row(input logic [5:0] row);
        cell_t slot;
        logic  snd;
        for (int c = 0; c < CHANNELS; c++)
        begin
            slot = song[(int'(row) % ROWS) * CHANNELS + c];
            snd  = (slot.note != NOTE_EMPTY) && (slot.note != NOTE_OFF);
            if (slot.effect == EFF_TEMPO)
            begin
                if (slot.param == PARAM_HALT)
                    running = 1'b0;
                else
                    speed = slot.param;
            end
            push_cmd(3'(c), 1'b0, slot.note != NOTE_EMPTY, slot.patch, snd, slot.note, snd);
        end
    endfunction

    // returns the number of commands queued for this transfer
    function automatic int predict_cmds(input stim_t s);
        int        n0;
        int        nxt;
        int        sp;
        logic      snd;
        chan_cmd_t e;
        n0 = pending_cmds.size();
        case (s.op)
            OP_TICK:
                if (running)
                begin
                    nxt = int'(tick_cnt) + 1;
                    sp  = (speed == 8'd0) ? 1 : int'(speed);
                    if (nxt % sp == 0 || nxt > 255)
                    begin
                        tick_cnt = 8'd0;
                        head_row = 6'((int'(head_row) + 1) % ROWS);
                        fire_row(head_row);
                    end
                    else
                        tick_cnt = 8'(nxt);
                end
            OP_START:
            begin
                if (running)
                    halt_channels();
                running  = 1'b1;
                head_row = 6'(int'(s.row) % ROWS);
                tick_cnt = 8'd0;
                fire_row(head_row);
            end
            OP_STOP:
                halt_channels();
            OP_REPLAY:
            begin
                if (running)
                    halt_channels();
                fire_row(s.row);
            end
            OP_JAM:
                if (s.ch < CHANNELS)
                begin
                    snd = (s.note != NOTE_EMPTY) && (s.note != NOTE_OFF);
                    push_cmd(s.ch, 1'b0, 1'b1, snd ? s.patch : 8'd0, snd, s.note, snd);
                end
            OP_WRITE_CELL:
                if (s.ch < CHANNELS)
                    song[(int'(s.row) % ROWS) * CHANNELS + int'(s.ch)] =
                        '{param: s.par, effect: s.eff, patch: s.patch, note: s.note};
            default:
                ;
        endcase
        if (pending_cmds.size() == n0)
            push_cmd(3'd0, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
        e      = pending_cmds.pop_back();
        e.last = 1'b1;
        pending_cmds.push_back(e);
        return pending_cmds.size() - n0;
    endfunction

    function automatic stim_t rand_stim();
        stim_t s;
        int    pick;
        s    = '0;
        pick = $urandom_range(99);
        if (pick < 38)
            s.op = OP_TICK;
        else if (pick < 62)
            s.op = OP_WRITE_CELL;
        else if (pick < 70)
            s.op = OP_START;
        else if (pick < 74)
            s.op = OP_STOP;
        else if (pick < 80)
            s.op = OP_REPLAY;
        else if (pick < 96)
            s.op = OP_JAM;
        else
            s.op = 3'($urandom_range(7));
        s.row = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(7));
        s.ch  = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(CHANNELS - 1));
        pick  = $urandom_range(9);
        if (pick == 0)
            s.note = NOTE_EMPTY;
        else if (pick == 1)
            s.note = NOTE_OFF;
        else if (pick == 2)
            s.note = 8'($urandom);
        else
            s.note = 8'($urandom_range(120, 1));
        s.patch = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        s.eff   = ($urandom_range(3) == 0) ? EFF_TEMPO : 4'($urandom);
        if (s.eff == EFF_TEMPO)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                s.par = PARAM_HALT;
            else if (pick == 1)
                s.par = 8'($urandom);
            else
                s.par = 8'($urandom_range(4, 1));
        end
        else
            s.par = 8'($urandom);
        return s;
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0d] mismatch: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic cmp_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_cmd();
        chan_cmd_t e;
        out_t      got;
        if (pending_cmds.size() == 0)
            report($sformatf("unexpected command 0x%010h last %0b", m_tdata, m_tlast));
        else
        begin
            e   = pending_cmds.pop_front();
            got = out_t'(m_tdata[35:0]);
            cmp_field("out_channel",  int'(got.out_channel),  int'(e.cmd.out_channel));
            cmp_field("full_release", int'(got.full_release), int'(e.cmd.full_release));
            cmp_field("key_off",      int'(got.key_off),      int'(e.cmd.key_off));
            cmp_field("load_patch",   int'(got.load_patch),   int'(e.cmd.load_patch));
            cmp_field("set_note",     int'(got.set_note),     int'(e.cmd.set_note));
            cmp_field("octave_block", int'(got.octave_block), int'(e.cmd.octave_block));
            cmp_field("freq_number",  int'(got.freq_number),  int'(e.cmd.freq_number));
            cmp_field("key_on",       int'(got.key_on),       int'(e.cmd.key_on));
            cmp_field("cur_row",      int'(got.cur_row),      int'(e.cmd.cur_row));
            cmp_field("is_playing",   int'(got.is_playing),   int'(e.cmd.is_playing));
            cmp_field("last",         int'(m_tlast),          int'(e.last));
        end
    endtask

    task automatic send(input stim_t s, output int added);
        while (!quiet && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, s.par, s.eff, s.patch, s.note, s.ch, s.row};
        s_tuser  <= s.op;
        do
            @(posedge clk);
        while (!s_tready);
        added = predict_cmds(s);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_cmd();
            m_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        int        added;
        chan_cmd_t idle_status;

        foreach (song[i])
            song[i] = '0;
        head_row = 6'd0;
        tick_cnt = 8'd0;
        speed    = SPEED_RESET;
        running  = 1'b0;

        idle_status      = '0;
        idle_status.last = 1'b1;

        //               op             row ch  note      patch  eff        par    typed
        dir_tbl[0]  = '{OP_TICK,       0,  0,  0,        0,     EFF_NONE,  0,     1'b1};
        dir_tbl[1]  = '{OP_RSVD6,      0,  0,  0,        0,     EFF_NONE,  0,     1'b1};
        dir_tbl[2]  = '{OP_RSVD7,      63, 7,  NOTE_OFF, 255,   EFF_TEMPO, 255,   1'b1};
        dir_tbl[3]  = '{OP_JAM,        0,  6,  60,       3,     EFF_NONE,  0,     1'b1};
        dir_tbl[4]  = '{OP_WRITE_CELL, 5,  7,  40,       4,     EFF_TEMPO, 1,     1'b1};
        dir_tbl[5]  = '{OP_WRITE_CELL, 0,  0,  1,        255,   EFF_NONE,  0,     1'b1};
        dir_tbl[6]  = '{OP_WRITE_CELL, 0,  1,  120,      1,     EFF_NONE,  0,     1'b1};
        dir_tbl[7]  = '{OP_WRITE_CELL, 0,  2,  NOTE_OFF, 7,     EFF_NONE,  0,     1'b1};
        dir_tbl[8]  = '{OP_WRITE_CELL, 0,  5,  254,      0,     EFF_NONE,  0,     1'b1};
        dir_tbl[9]  = '{OP_WRITE_CELL, 1,  3,  13,       2,     EFF_TEMPO, 2,     1'b1};
        dir_tbl[10] = '{OP_WRITE_CELL, 63, 4,  60,       0,     EFF_TEMPO, 0,     1'b1};
        dir_tbl[11] = '{OP_WRITE_CELL, 2,  0,  0,        0,     EFF_TEMPO, 255,   1'b1};
        dir_tbl[12] = '{OP_WRITE_CELL, 3,  1,  37,       0,     EFF_PLAIN, 255,   1'b1};
        dir_tbl[13] = '{OP_START,      0,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[14] = '{OP_STOP,       0,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[15] = '{OP_STOP,       0,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[16] = '{OP_REPLAY,     63, 0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[17] = '{OP_START,      1,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[18] = '{OP_TICK,       0,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[19] = '{OP_TICK,       0,  0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[20] = '{OP_START,      63, 0,  0,        0,     EFF_NONE,  0,     1'b0};
        dir_tbl[21] = '{OP_JAM,        0,  0,  NOTE_EMPTY, 5,   EFF_NONE,  0,     1'b0};
        dir_tbl[22] = '{OP_JAM,        0,  5,  NOTE_OFF, 9,     EFF_NONE,  0,     1'b0};
        dir_tbl[23] = '{OP_JAM,        0,  3,  120,      255,   EFF_NONE,  0,     1'b0};
        dir_tbl[24] = '{OP_REPLAY,     2,  0,  0,        0,     EFF_NONE,  0,     1'b0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ITEMS; i++)
        begin
            send(dir_tbl[i], added);
            // an idle op yields one all-zero status command with playback stopped at row 0
            if (dir_tbl[i].typed)
            begin
                repeat (added) void'(pending_cmds.pop_back());
                pending_cmds.push_back(idle_status);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 150 && i < 270);
            send(rand_stim(), added);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/trs_pkg.sv
sv/trs_front.sv
sv/trs_cmd_queue.sv
sv/trs_back.sv
sv/tracker_row_sequencer.sv
sim/tracker_row_sequencer_tb.sv
